// ===== rtl/core/nkmt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nkmt_pkg
// shared types and constants for the nearest key momentum table
// ----------------------------------------------------------------------------
package nkmt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int CODE_W = 31;
   localparam int MOM_W  = 16;
   localparam int NUC_W  = 15;
   localparam int STAT_W = 3;
   localparam int Z_W    = 10;
   localparam int QUO_W  = 18;
   localparam int KQ_W   = 8;

   localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);

   // code / 10000 as (code * RECIP_HI) >> SHIFT_HI, exact for 31 bit codes
   localparam int RECIP_HI_W = 32;
   localparam int SHIFT_HI   = 45;
   localparam int PROD_HI_W  = CODE_W + RECIP_HI_W;
   localparam logic [RECIP_HI_W-1:0] RECIP_HI = 32'd3518437209;

   // q / 1000 as (q * RECIP_LO) >> SHIFT_LO, exact for 18 bit q
   localparam int RECIP_LO_W = 19;
   localparam int SHIFT_LO   = 28;
   localparam int PROD_LO_W  = QUO_W + RECIP_LO_W;
   localparam logic [RECIP_LO_W-1:0] RECIP_LO = 19'd268436;

   localparam logic [QUO_W-1:0] DIV_LO  = 18'd1000;
   localparam logic [Z_W-1:0]   Z_LIMIT = 10'd1000;

   localparam logic [NUC_W-1:0] PROTON_CODE = 15'd2212;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_EXACT     = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_NEAREST   = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY     = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_INSERTED  = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_DUPLICATE = 3'd4;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd5;

   typedef struct packed {
      logic [Z_W-1:0]    charge;
      logic [CODE_W-1:0] key;
      logic [MOM_W-1:0]  proton;
      logic [MOM_W-1:0]  neutron;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage : nkmt_pkg
`default_nettype wire

// ===== rtl/core/nkmt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nkmt_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module nkmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : nkmt_ram
`default_nettype wire

// ===== rtl/core/nearest_key_momentum_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_key_momentum_table
// target code table with exact or nearest charge momentum lookup
//
//   channel  dir  ports                                  meaning
//   req      in   req_valid req_stall req_mode ...       insert or query
//   rsp      out  rsp_valid rsp_stall rsp_momentum ...   momentum and status
//
// a request passes through code / 10000, the quotient by 1000 and the
// charge, then one table ram read per stored entry, then a drain of the
// last read and the finish step
// a new request is taken the cycle after the result enters the output
// register; a stalled result holds the block in its last step
// synchronous reset empties the table, no clearing pass is needed
// ----------------------------------------------------------------------------
module nearest_key_momentum_table
   import nkmt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic              req_mode,
   input  wire logic [CODE_W-1:0] req_target_code,
   input  wire logic [MOM_W-1:0]  req_proton_momentum,
   input  wire logic [MOM_W-1:0]  req_neutron_momentum,
   input  wire logic signed [NUC_W-1:0] req_nucleon_code,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [MOM_W-1:0]  rsp_momentum,
   output      logic [STAT_W-1:0] rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_HI,
      ST_DIV_LO,
      ST_DIV_REM,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type         state_ff,     state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   logic              rd_vld_ff,    rd_vld_in;

   logic              mode_ff,      mode_in;
   logic [CODE_W-1:0] code_ff,      code_in;
   logic [MOM_W-1:0]  pm_ff,        pm_in;
   logic [MOM_W-1:0]  nm_ff,        nm_in;
   logic              proton_ff,    proton_in;
   logic [QUO_W-1:0]  quo_ff,       quo_in;
   logic [KQ_W-1:0]   kq_ff,        kq_in;
   logic [Z_W-1:0]    z_ff,         z_in;
   logic [CNT_W-1:0]  idx_ff,       idx_in;
   logic              have_ff,      have_in;
   logic              found_ff,     found_in;
   logic [Z_W-1:0]    best_dz_ff,   best_dz_in;
   logic [CODE_W-1:0] best_key_ff,  best_key_in;
   logic [MOM_W-1:0]  best_pm_ff,   best_pm_in;
   logic [MOM_W-1:0]  best_nm_ff,   best_nm_in;
   logic [MOM_W-1:0]  exact_pm_ff,  exact_pm_in;
   logic [MOM_W-1:0]  exact_nm_ff,  exact_nm_in;
   logic [MOM_W-1:0]  momentum_ff,  momentum_in;
   logic [STAT_W-1:0] status_ff,    status_in;

   // constant division by reciprocal multiply
   logic [PROD_HI_W-1:0] hi_prod;
   logic [PROD_LO_W-1:0] lo_prod;
   logic [QUO_W-1:0]     kilo_full;
   logic [QUO_W-1:0]     z_full;

   // table ram
   logic              ram_wr_en;
   logic              ram_rd_en;
   entry_type         ram_wr_data;
   entry_type         ram_rd_data;
   logic [ENTRY_W-1:0] ram_rd_raw;

   // scan compare
   logic [Z_W-1:0]    dz;
   logic              better;
   logic              out_free;

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_momentum = momentum_ff;
   assign rsp_status   = status_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign hi_prod   = PROD_HI_W'(code_ff) * PROD_HI_W'(RECIP_HI);
   assign lo_prod   = PROD_LO_W'(quo_ff) * PROD_LO_W'(RECIP_LO);
   assign kilo_full = QUO_W'(kq_ff) * DIV_LO;
   assign z_full    = quo_ff - kilo_full;

   assign ram_rd_en   = (state_ff == ST_SCAN) && (idx_ff < count_ff);
   assign ram_wr_en   = (state_ff == ST_FINISH) && out_free && (mode_ff == MODE_INSERT)
                        && !found_ff && (count_ff != TABLE_FULL);
   assign ram_wr_data = '{charge: z_ff, key: code_ff, proton: pm_ff, neutron: nm_ff};
   assign ram_rd_data = entry_type'(ram_rd_raw);

   assign dz     = (ram_rd_data.charge > z_ff) ? (ram_rd_data.charge - z_ff)
                                               : (z_ff - ram_rd_data.charge);
   assign better = !have_ff || (dz < best_dz_ff)
                   || ((dz == best_dz_ff) && (ram_rd_data.key < best_key_ff));

   nkmt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_raw)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      rd_vld_in    = 1'b0;
      mode_in      = mode_ff;
      code_in      = code_ff;
      pm_in        = pm_ff;
      nm_in        = nm_ff;
      proton_in    = proton_ff;
      quo_in       = quo_ff;
      kq_in        = kq_ff;
      z_in         = z_ff;
      idx_in       = idx_ff;
      have_in      = have_ff;
      found_in     = found_ff;
      best_dz_in   = best_dz_ff;
      best_key_in  = best_key_ff;
      best_pm_in   = best_pm_ff;
      best_nm_in   = best_nm_ff;
      exact_pm_in  = exact_pm_ff;
      exact_nm_in  = exact_nm_ff;
      momentum_in  = momentum_ff;
      status_in    = status_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               code_in   = req_target_code;
               pm_in     = req_proton_momentum;
               nm_in     = req_neutron_momentum;
               proton_in = (req_nucleon_code == PROTON_CODE);
               state_in  = ST_DIV_HI;
            end
         end
         ST_DIV_HI: begin
            quo_in   = hi_prod[SHIFT_HI +: QUO_W];
            state_in = ST_DIV_LO;
         end
         ST_DIV_LO: begin
            kq_in    = lo_prod[SHIFT_LO +: KQ_W];
            state_in = ST_DIV_REM;
         end
         ST_DIV_REM: begin
            z_in     = z_full[Z_W-1:0];
            idx_in   = '0;
            have_in  = 1'b0;
            found_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_vld_in = ram_rd_en;
            if (ram_rd_en) begin
               idx_in = idx_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (ram_rd_data.key == code_ff) begin
                  found_in    = 1'b1;
                  exact_pm_in = ram_rd_data.proton;
                  exact_nm_in = ram_rd_data.neutron;
               end
               if (better) begin
                  have_in     = 1'b1;
                  best_dz_in  = dz;
                  best_key_in = ram_rd_data.key;
                  best_pm_in  = ram_rd_data.proton;
                  best_nm_in  = ram_rd_data.neutron;
               end
            end
            if (!ram_rd_en && !rd_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               momentum_in  = '0;
               if (mode_ff == MODE_INSERT) begin
                  if (found_ff) begin
                     status_in = STATUS_DUPLICATE;
                  end else if (count_ff == TABLE_FULL) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in = STATUS_INSERTED;
                     count_in  = count_ff + 1'b1;
                  end
               end else if (found_ff) begin
                  status_in   = STATUS_EXACT;
                  momentum_in = proton_ff ? exact_pm_ff : exact_nm_ff;
               end else if (have_ff) begin
                  status_in   = STATUS_NEAREST;
                  momentum_in = proton_ff ? best_pm_ff : best_nm_ff;
               end else begin
                  status_in = STATUS_EMPTY;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
      end
      mode_ff     <= mode_in;
      code_ff     <= code_in;
      pm_ff       <= pm_in;
      nm_ff       <= nm_in;
      proton_ff   <= proton_in;
      quo_ff      <= quo_in;
      kq_ff       <= kq_in;
      z_ff        <= z_in;
      idx_ff      <= idx_in;
      have_ff     <= have_in;
      found_ff    <= found_in;
      best_dz_ff  <= best_dz_in;
      best_key_ff <= best_key_in;
      best_pm_ff  <= best_pm_in;
      best_nm_ff  <= best_nm_in;
      exact_pm_ff <= exact_pm_in;
      exact_nm_ff <= exact_nm_in;
      momentum_ff <= momentum_in;
      status_ff   <= status_in;
   end

   // table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= TABLE_FULL)
      else $error("entry count beyond table size");

   // table only grows by one, and only with an inserted result
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
      |-> ((count_ff == $past(count_ff) + 1'b1) && rsp_valid_ff
           && (status_ff == STATUS_INSERTED)))
      else $error("entry count changed without insert");

   // result appears only out of the last step
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish step");

   // charge from the divider is in range while scanning
   a_z_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (z_ff < Z_LIMIT))
      else $error("charge out of range");

   // an exact match always carries a nearest candidate
   a_found_have: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && found_ff) |-> have_ff)
      else $error("exact match without candidate");

endmodule : nearest_key_momentum_table
`default_nettype wire

// ===== sim/nearest_key_momentum_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_key_momentum_table_test
// self-checking bench for the target code momentum table
//
// Requests are sent with random gaps, and results are taken with random
// stalls. A behavioral copy of the table predicts every result: an insert
// gives inserted, duplicate or full, and a query gives an exact match, the
// nearest charge with the smallest code on a tie, or empty. Each result is
// compared field by field, in order. Directed cases come first, then random
// traffic while the table fills, then the full table, then random traffic
// on the full table.
// ----------------------------------------------------------------------------
module nearest_key_momentum_table_test;
   import nkmt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [NUC_W-1:0] NEUTRON_CODE = 15'd2112;

   typedef struct packed {
      logic [MOM_W-1:0]  momentum;
      logic [STAT_W-1:0] status;
   } reply_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_mode;
   logic [CODE_W-1:0] req_target_code;
   logic [MOM_W-1:0]  req_proton_momentum;
   logic [MOM_W-1:0]  req_neutron_momentum;
   logic signed [NUC_W-1:0] req_nucleon_code;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [MOM_W-1:0]  rsp_momentum;
   logic [STAT_W-1:0] rsp_status;

   // copy of the table as the block should hold it
   logic [CODE_W-1:0] known_key [TABLE_ENTRIES];
   logic [MOM_W-1:0]  known_proton [TABLE_ENTRIES];
   logic [MOM_W-1:0]  known_neutron [TABLE_ENTRIES];
   int unsigned       known_count;

   reply_type expected_replies [$];
   int        error_count;
   int        request_count;
   int        reply_count;
   int        status_seen [8];
   int        cycle_count;
   logic      steady;

   nearest_key_momentum_table dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_target_code      (req_target_code),
      .req_proton_momentum  (req_proton_momentum),
      .req_neutron_momentum (req_neutron_momentum),
      .req_nucleon_code     (req_nucleon_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_momentum         (rsp_momentum),
      .rsp_status           (rsp_status)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int unsigned charge_of_code(input logic [CODE_W-1:0] code);
      int unsigned c;
      c = code;
      return (c / 10000) % 1000;
   endfunction

   function automatic bit is_stored(input logic [CODE_W-1:0] code);
      for (int unsigned i = 0; i < known_count; i++) begin
         if (known_key[i] == code) return 1'b1;
      end
      return 1'b0;
   endfunction

   // updates the table copy and returns the result the block owes
   function automatic reply_type predict_reply(input logic mode,
                                               input logic [CODE_W-1:0] code,
                                               input logic [MOM_W-1:0] pm,
                                               input logic [MOM_W-1:0] nm,
                                               input logic [NUC_W-1:0] nuc);
      reply_type   r;
      int unsigned best;
      int unsigned best_dz;
      int unsigned dz;
      int unsigned zq;
      int unsigned ze;
      bit          found;
      r.momentum = '0;
      best = 0;
      best_dz = 0;
      found = 1'b0;
      if (mode == MODE_INSERT) begin
         if (is_stored(code)) begin
            r.status = STATUS_DUPLICATE;
         end else if (known_count >= TABLE_ENTRIES) begin
            r.status = STATUS_FULL;
         end else begin
            known_key[known_count] = code;
            known_proton[known_count] = pm;
            known_neutron[known_count] = nm;
            known_count++;
            r.status = STATUS_INSERTED;
         end
      end else if (known_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         for (int unsigned i = 0; i < known_count; i++) begin
            if (known_key[i] == code) begin
               found = 1'b1;
               best = i;
            end
         end
         if (found) begin
            r.status = STATUS_EXACT;
         end else begin
            zq = charge_of_code(code);
            for (int unsigned i = 0; i < known_count; i++) begin
               ze = charge_of_code(known_key[i]);
               dz = (ze > zq) ? ze - zq : zq - ze;
               if (i == 0 || dz < best_dz ||
                   (dz == best_dz && known_key[i] < known_key[best])) begin
                  best = i;
                  best_dz = dz;
               end
            end
            r.status = STATUS_NEAREST;
         end
         r.momentum = (nuc == PROTON_CODE) ? known_proton[best] : known_neutron[best];
      end
      return r;
   endfunction

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic send_request(input logic mode, input logic [CODE_W-1:0] code,
                               input logic [MOM_W-1:0] pm, input logic [MOM_W-1:0] nm,
                               input logic [NUC_W-1:0] nuc);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_target_code <= code;
      req_proton_momentum <= pm;
      req_neutron_momentum <= nm;
      req_nucleon_code <= nuc;
      do @(posedge clock); while (req_stall);
      expected_replies.push_back(predict_reply(mode, code, pm, nm, nuc));
      request_count++;
   endtask

   function automatic logic [NUC_W-1:0] pick_nucleon();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return PROTON_CODE;
      if (sel < 7) return NEUTRON_CODE;
      return NUC_W'($urandom);
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      int unsigned sel;
      int unsigned z;
      sel = $urandom_range(0, 9);
      if (sel < 2) return CODE_W'($urandom);
      if (sel < 8 || known_count == 0) begin
         z = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 120);
         return CODE_W'(32'd1000000000 + z * 10000 + $urandom_range(0, 299) * 10 +
                        $urandom_range(0, 9));
      end
      return known_key[$urandom_range(0, known_count - 1)] +
             CODE_W'($urandom_range(1, 60) * 10);
   endfunction

   // result side: stall for a drawn number of cycles, then take the result
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = draw_wait();
         @(negedge clock);
         rsp_stall <= (n != 0);
         do @(posedge clock); while (reset || !rsp_valid);
         if (n != 0) begin
            repeat (n - 1) @(posedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
         end
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         reply_count++;
         if (expected_replies.size() == 0) begin
            error_count++;
            $display("%0t: result with no request waiting, momentum %h status %0d",
                     $time, rsp_momentum, rsp_status);
         end else begin
            want = expected_replies.pop_front();
            status_seen[want.status]++;
            if (rsp_status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
            end
            if (rsp_momentum !== want.momentum) begin
               error_count++;
               $display("%0t: momentum expected %h actual %h", $time, want.momentum,
                        rsp_momentum);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_replies.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_empty_query();
      send_request(MODE_QUERY, CODE_W'(32'd1000060120), 16'hFFFF, 16'hFFFF, PROTON_CODE);
      send_request(MODE_QUERY, '1, 16'h0000, 16'h0000, NEUTRON_CODE);
   endtask

   task automatic test_insert_extremes();
      send_request(MODE_INSERT, '0, 16'h0000, 16'hFFFF, 15'h7FFF);
      send_request(MODE_INSERT, '1, 16'hFFFF, 16'h0000, 15'h4000);
      send_request(MODE_INSERT, CODE_W'(32'd1000060120), 16'h3A21, 16'h3B42, '0);
      send_request(MODE_INSERT, CODE_W'(32'd1000080160), 16'h3C63, 16'h3D84, PROTON_CODE);
      send_request(MODE_INSERT, CODE_W'(32'd1000260560), 16'h3EA5, 16'h3FC6, NEUTRON_CODE);
      send_request(MODE_INSERT, CODE_W'(32'd1000260540), 16'h40E7, 16'h4108, 15'h5555);
      // same code again with other momenta
      send_request(MODE_INSERT, CODE_W'(32'd1000060120), 16'h1111, 16'h2222, 15'h2AAA);
   endtask

   task automatic test_exact_query();
      send_request(MODE_QUERY, CODE_W'(32'd1000060120), 16'hAAAA, 16'h5555, PROTON_CODE);
      send_request(MODE_QUERY, CODE_W'(32'd1000060120), 16'h5555, 16'hAAAA, NEUTRON_CODE);
      // negative proton code selects the neutron value
      send_request(MODE_QUERY, CODE_W'(32'd1000060120), 16'h0F0F, 16'hF0F0, -15'sd2212);
      send_request(MODE_QUERY, '0, 16'hFFFF, 16'h0000, 15'd2213);
      send_request(MODE_QUERY, '1, 16'h0000, 16'hFFFF, PROTON_CODE);
   endtask

   task automatic test_nearest_query();
      // equal distance to carbon and oxygen, smaller code wins
      send_request(MODE_QUERY, CODE_W'(32'd1000070140), 16'h1234, 16'h5678, PROTON_CODE);
      send_request(MODE_QUERY, CODE_W'(32'd1000200400), 16'h9ABC, 16'hDEF0, NEUTRON_CODE);
      // same charge, two codes
      send_request(MODE_QUERY, CODE_W'(32'd1000260570), 16'h0001, 16'h8000, PROTON_CODE);
      send_request(MODE_QUERY, CODE_W'(32'd1009990000), 16'h7FFF, 16'hFFFE, 15'h3FFF);
   endtask

   task automatic random_traffic(input int count, input int insert_pct);
      logic [CODE_W-1:0] code;
      for (int k = 0; k < count; k++) begin
         if (k % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < insert_pct) begin
            if (known_count > 0 && $urandom_range(0, 3) == 0)
               code = known_key[$urandom_range(0, known_count - 1)];
            else
               code = pick_code();
            send_request(MODE_INSERT, code, MOM_W'($urandom), MOM_W'($urandom),
                         pick_nucleon());
         end else begin
            if (known_count > 0 && $urandom_range(0, 1) == 0)
               code = known_key[$urandom_range(0, known_count - 1)];
            else
               code = pick_code();
            send_request(MODE_QUERY, code, MOM_W'($urandom), MOM_W'($urandom),
                         pick_nucleon());
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_full_table();
      logic [CODE_W-1:0] code;
      while (known_count < TABLE_ENTRIES)
         send_request(MODE_INSERT, pick_code(), MOM_W'($urandom), MOM_W'($urandom),
                      pick_nucleon());
      do code = pick_code(); while (is_stored(code));
      send_request(MODE_INSERT, code, 16'hFFFF, 16'hFFFF, PROTON_CODE);
      // duplicate is reported ahead of full
      send_request(MODE_INSERT, known_key[TABLE_ENTRIES - 1], 16'h0000, 16'h0000,
                   NEUTRON_CODE);
      send_request(MODE_QUERY, known_key[TABLE_ENTRIES - 1], 16'h0000, 16'h0000,
                   PROTON_CODE);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_INSERT;
      req_target_code = '0;
      req_proton_momentum = '0;
      req_neutron_momentum = '0;
      req_nucleon_code = '0;
      steady = 1'b0;
      known_count = 0;
      error_count = 0;
      request_count = 0;
      reply_count = 0;
      cycle_count = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_query();
      test_insert_extremes();
      test_exact_query();
      test_nearest_query();
      random_traffic(300, 40);
      test_full_table();
      random_traffic(1200, 15);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests, %0d results, %0d table entries in use", request_count,
               reply_count, known_count);
      $display("exact %0d, nearest %0d, empty %0d, inserted %0d, duplicate %0d, full %0d",
               status_seen[STATUS_EXACT], status_seen[STATUS_NEAREST],
               status_seen[STATUS_EMPTY], status_seen[STATUS_INSERTED],
               status_seen[STATUS_DUPLICATE], status_seen[STATUS_FULL]);
      if (error_count == 0 && expected_replies.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
